// ----- rtl/gray_level_size_zone_matrix_defines.svh -----
// Assertion macros shared by the gray level size zone matrix RTL.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef GRAY_LEVEL_SIZE_ZONE_MATRIX_DEFINES_SVH
`define GRAY_LEVEL_SIZE_ZONE_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GLSZM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define GLSZM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/glszm_pkg.sv -----
// Package for the gray level size zone matrix: state type, codes and the
// neighbor direction table. Depends on nothing.
`timescale 1ns / 1ps

package glszm_pkg;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_QWAIT, S_CLR_RD, S_CLR_WR, S_RANK, S_SCAN_RD, S_SCAN_CHK,
    S_POP, S_POP_DATA, S_NBR_ADDR, S_NBR_RD, S_NBR_CHK, S_ZONE_RD, S_ZONE_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {DIR_MINUS, DIR_ZERO, DIR_PLUS} dir_t;

  localparam logic [1:0] CFG_IBSI   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] NBR_LAST = 3'd7;

  // Row step of each of the eight neighbors
  function automatic dir_t nbr_dy(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd0, 3'd1, 3'd2: d = DIR_MINUS;
      3'd3, 3'd4:       d = DIR_ZERO;
      default:          d = DIR_PLUS;
    endcase
    return d;
  endfunction

  // Column step of each of the eight neighbors
  function automatic dir_t nbr_dx(input logic [2:0] k);
    dir_t d;
    case (k)
      3'd0, 3'd3, 3'd5: d = DIR_MINUS;
      3'd1, 3'd6:       d = DIR_ZERO;
      default:          d = DIR_PLUS;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/glszm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module glszm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gray_level_size_zone_matrix.sv -----
// Pixel load: one word per cycle while not busy. Query: the matrix word read at accept
// is registered out from S_QWAIT; busy is high in S_QWAIT, so no query overlaps it.
// Last pixel: the previous frame's matrix entries are cleared, the levels are ranked,
// the pixels are scanned and each zone grown over its eight neighbors; then the summary.
// Reset: synchronous; an S_INIT pass then zeroes the matrix while busy is high.
// The receiver cannot stall: each result sits on the ports for one strobed cycle.
`timescale 1ns / 1ps
`include "gray_level_size_zone_matrix_defines.svh"

module gray_level_size_zone_matrix #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int NUM_LEVELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [5:0]  pixel_level,
  input  logic [4:0]  query_row,
  input  logic [12:0] query_size,
  output logic        result_strobe,
  output logic        result_kind,
  output logic [12:0] zone_count,
  output logic [5:0]  row_level,
  output logic [12:0] zone_total,
  output logic [12:0] pixel_total,
  output logic [5:0]  level_total,
  output logic [12:0] largest_zone,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  import glszm_pkg::*;

  localparam int FRAME_MAX = MAX_WIDTH * MAX_HEIGHT;
  localparam int PAW    = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam int CNT_W  = $clog2(FRAME_MAX + 1);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int LW     = $clog2(NUM_LEVELS + 1);
  localparam int RW     = $clog2(NUM_LEVELS);
  localparam int SW     = YW + XW;
  localparam int MAW    = RW + PAW;
  localparam int MDEPTH = NUM_LEVELS * (2 ** PAW);

  state_t state, state_next;

  // configuration
  logic          ibsi_mode;
  logic [6:0]    image_width, image_height;

  // frame state
  logic [CNT_W-1:0]      frame_pixels;
  logic [PAW-1:0]        load_position;
  logic [NUM_LEVELS-1:0] levels_present;
  logic [CNT_W-1:0]      zone_counter, nonzero_counter, biggest_zone;
  logic                  latched_ibsi;
  logic [LW-1:0]         latched_rows;
  logic [WW-1:0]         label_w;
  logic [HW-1:0]         label_h;
  logic [CNT_W-1:0]      label_n;
  logic [CNT_W-1:0]      touched_cnt, clr_idx;
  logic [MAW-1:0]        init_addr;

  // level ranking
  logic [RW-1:0] lvl_i;
  logic [LW-1:0] distinct, highest;
  logic [RW-1:0] rank_of [NUM_LEVELS];
  logic [LW-1:0] level_of_rank [NUM_LEVELS];

  // labeling walk
  logic [PAW-1:0]   scan_p;
  logic [XW-1:0]    scan_x, q_x, nbr_x;
  logic [YW-1:0]    scan_y, q_y, nbr_y;
  logic [LW-1:0]    zone_lev;
  logic [CNT_W-1:0] zone_size, sp;
  logic [2:0]       nbr_k;
  logic [PAW-1:0]   nbr_addr;

  // query capture
  logic       query_ok;
  logic [5:0] query_level;

  // memory ports
  logic           pix_we;
  logic [PAW-1:0] pix_waddr, pix_raddr;
  logic [LW:0]    pix_wdata, pix_rdata;
  logic           stk_we;
  logic [PAW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0]  stk_wdata, stk_rdata;
  logic           mat_we;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [CNT_W-1:0] mat_wdata, mat_rdata;
  logic           tch_we;
  logic [PAW-1:0] tch_waddr, tch_raddr;
  logic [MAW-1:0] tch_wdata, tch_rdata;

  // combinational helpers
  logic            accept, load_accept, load_first, load_last;
  logic [LW-1:0]   lev_in;
  logic [NUM_LEVELS-1:0] lev_bit;
  logic [WW-1:0]   w_cl;
  logic [HW-1:0]   h_cl;
  logic            pix_vis;
  logic [LW-1:0]   pix_lev;
  logic            zone_start, scan_last, nbr_match;
  dir_t            dy, dx;
  logic            nbr_ok;
  logic [YW-1:0]   ny;
  logic [XW-1:0]   nx;
  logic [PAW-1:0]  nbr_lin;
  logic [RW-1:0]   zrow;
  logic [MAW-1:0]  zone_maddr, query_maddr;
  logic            query_ok_c;
  logic [5:0]      query_level_c;
  logic            rank_present;
  logic [LW-1:0]   distinct_n, highest_n;

  // ---------------------------------------------------------------- memories
  glszm_ram #(.WIDTH(LW + 1), .DEPTH(FRAME_MAX)) u_pixel_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  glszm_ram #(.WIDTH(SW), .DEPTH(FRAME_MAX)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  glszm_ram #(.WIDTH(CNT_W), .DEPTH(MDEPTH)) u_matrix_ram (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  glszm_ram #(.WIDTH(MAW), .DEPTH(FRAME_MAX)) u_touched_ram (
    .clk(clk), .we(tch_we), .waddr(tch_waddr), .wdata(tch_wdata),
    .raddr(tch_raddr), .rdata(tch_rdata)
  );

  // ---------------------------------------------------------------- helpers
  assign busy        = (state != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = start && !busy;
  assign load_accept = accept && (mode == MODE_LOAD);
  assign load_first  = (load_position == '0);
  assign load_last   = (CNT_W'(load_position) + CNT_W'(1)) >= frame_pixels;

  // Saturate the level and clamp the frame dimensions
  always_comb begin
    if (32'(pixel_level) > NUM_LEVELS) begin
      lev_in = LW'(NUM_LEVELS);
    end else begin
      lev_in = LW'(pixel_level);
    end
    lev_bit = (lev_in != '0) ? (NUM_LEVELS'(1) << (lev_in - LW'(1))) : '0;
    if (image_width == '0) begin
      w_cl = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(image_width);
    end
    if (image_height == '0) begin
      h_cl = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(image_height);
    end
    frame_pixels = CNT_W'(32'(w_cl) * 32'(h_cl));
  end

  assign pix_vis    = pix_rdata[LW];
  assign pix_lev    = pix_rdata[LW-1:0];
  assign zone_start = (pix_lev != '0) && !pix_vis;
  assign scan_last  = (CNT_W'(scan_p) + CNT_W'(1)) == label_n;
  assign nbr_match  = !pix_vis && (pix_lev == zone_lev);

  // Neighbor coordinates and bounds
  always_comb begin
    dy     = nbr_dy(nbr_k);
    dx     = nbr_dx(nbr_k);
    nbr_ok = 1'b1;
    ny     = q_y;
    nx     = q_x;
    case (dy)
      DIR_MINUS: begin
        nbr_ok = nbr_ok && (q_y != '0);
        ny     = q_y - YW'(1);
      end
      DIR_PLUS: begin
        nbr_ok = nbr_ok && ((32'(q_y) + 1) < 32'(label_h));
        ny     = q_y + YW'(1);
      end
      default: ny = q_y;
    endcase
    case (dx)
      DIR_MINUS: begin
        nbr_ok = nbr_ok && (q_x != '0);
        nx     = q_x - XW'(1);
      end
      DIR_PLUS: begin
        nbr_ok = nbr_ok && ((32'(q_x) + 1) < 32'(label_w));
        nx     = q_x + XW'(1);
      end
      default: nx = q_x;
    endcase
    nbr_lin = PAW'(32'(ny) * 32'(label_w) + 32'(nx));
  end

  // Matrix addresses for a finished zone and for a query
  always_comb begin
    if (latched_ibsi) begin
      zrow = RW'(zone_lev - LW'(1));
    end else begin
      zrow = rank_of[RW'(zone_lev - LW'(1))];
    end
    zone_maddr  = {zrow, PAW'(zone_size - CNT_W'(1))};
    query_maddr = {RW'(query_row), PAW'(query_size - 13'd1)};
    query_ok_c  = (query_size != '0) && (32'(query_size) <= FRAME_MAX) &&
                  (32'(query_row) < 32'(latched_rows));
    if (latched_ibsi) begin
      query_level_c = 6'(query_row) + 6'd1;
    end else begin
      query_level_c = 6'(level_of_rank[RW'(query_row)]);
    end
  end

  // Rank sweep step
  always_comb begin
    rank_present = levels_present[lvl_i];
    distinct_n   = distinct + (rank_present ? LW'(1) : LW'(0));
    highest_n    = rank_present ? (LW'(lvl_i) + LW'(1)) : highest;
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_addr == MAW'(MDEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && (mode == MODE_QUERY)) begin
          state_next = S_QWAIT;
        end else if (load_accept && load_last) begin
          state_next = (touched_cnt != '0) ? S_CLR_RD : S_RANK;
        end
      end
      S_QWAIT:  state_next = S_IDLE;
      S_CLR_RD: state_next = S_CLR_WR;
      S_CLR_WR: begin
        state_next = ((clr_idx + CNT_W'(1)) == touched_cnt) ? S_RANK : S_CLR_RD;
      end
      S_RANK: begin
        if (lvl_i == RW'(NUM_LEVELS - 1)) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (zone_start) begin
          state_next = S_POP;
        end else begin
          state_next = scan_last ? S_DONE : S_SCAN_RD;
        end
      end
      S_POP:      state_next = (sp == '0) ? S_ZONE_RD : S_POP_DATA;
      S_POP_DATA: state_next = S_NBR_ADDR;
      S_NBR_ADDR: begin
        if (nbr_ok) begin
          state_next = S_NBR_RD;
        end else if (nbr_k == NBR_LAST) begin
          state_next = S_POP;
        end
      end
      S_NBR_RD:  state_next = S_NBR_CHK;
      S_NBR_CHK: state_next = (nbr_k == NBR_LAST) ? S_POP : S_NBR_ADDR;
      S_ZONE_RD: state_next = S_ZONE_WR;
      S_ZONE_WR: state_next = scan_last ? S_DONE : S_SCAN_RD;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory control
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = load_position;
    pix_wdata = {1'b0, lev_in};
    pix_raddr = scan_p;
    stk_we    = 1'b0;
    stk_waddr = PAW'(sp);
    stk_wdata = {nbr_y, nbr_x};
    stk_raddr = PAW'(sp - CNT_W'(1));
    mat_we    = 1'b0;
    mat_waddr = zone_maddr;
    mat_wdata = mat_rdata + CNT_W'(1);
    mat_raddr = zone_maddr;
    tch_we    = 1'b0;
    tch_waddr = PAW'(touched_cnt);
    tch_wdata = zone_maddr;
    tch_raddr = PAW'(clr_idx);
    case (state)
      S_INIT: begin
        mat_we    = 1'b1;
        mat_waddr = init_addr;
        mat_wdata = '0;
      end
      S_IDLE: begin
        pix_we    = load_accept;
        mat_raddr = query_maddr;
      end
      S_CLR_WR: begin
        mat_we    = 1'b1;
        mat_waddr = tch_rdata;
        mat_wdata = '0;
      end
      S_SCAN_CHK: begin
        pix_we    = zone_start;
        pix_waddr = scan_p;
        pix_wdata = {1'b1, pix_lev};
        stk_we    = zone_start;
        stk_waddr = '0;
        stk_wdata = {scan_y, scan_x};
      end
      S_NBR_RD: pix_raddr = nbr_addr;
      S_NBR_CHK: begin
        pix_we    = nbr_match;
        pix_waddr = nbr_addr;
        pix_wdata = {1'b1, zone_lev};
        stk_we    = nbr_match;
      end
      S_ZONE_WR: begin
        mat_we = 1'b1;
        tch_we = (mat_rdata == '0);
      end
      default: pix_we = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ibsi_mode    <= 1'b0;
      image_width  <= 7'd64;
      image_height <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IBSI:   ibsi_mode    <= cfg_data[0];
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default:    ibsi_mode    <= ibsi_mode;
      endcase
    end
  end

  // ---------------------------------------------------------------- state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      init_addr       <= '0;
      load_position   <= '0;
      levels_present  <= '0;
      zone_counter    <= '0;
      nonzero_counter <= '0;
      biggest_zone    <= '0;
      latched_ibsi    <= 1'b0;
      latched_rows    <= '0;
      touched_cnt     <= '0;
      sp              <= '0;
      result_strobe   <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      case (state)
        S_INIT: init_addr <= init_addr + MAW'(1);
        S_IDLE: begin
          if (accept && (mode == MODE_QUERY)) begin
            query_ok    <= query_ok_c;
            query_level <= query_level_c;
          end
          if (load_accept) begin
            // start a frame on its first word, then count this pixel
            if (load_first) begin
              levels_present  <= lev_bit;
              nonzero_counter <= CNT_W'(lev_in != '0);
              zone_counter    <= '0;
              biggest_zone    <= '0;
              latched_rows    <= '0;
            end else begin
              levels_present  <= levels_present | lev_bit;
              nonzero_counter <= nonzero_counter + CNT_W'(lev_in != '0);
            end
            if (load_last) begin
              load_position <= '0;
              label_w       <= w_cl;
              label_h       <= h_cl;
              label_n       <= frame_pixels;
              latched_ibsi  <= ibsi_mode;
              clr_idx       <= '0;
              lvl_i         <= '0;
              distinct      <= '0;
              highest       <= '0;
              scan_p        <= '0;
              scan_x        <= '0;
              scan_y        <= '0;
              sp            <= '0;
            end else begin
              load_position <= load_position + PAW'(1);
            end
          end
        end
        S_QWAIT: begin
          result_strobe <= 1'b1;
          result_kind   <= KIND_ANSWER;
          zone_count    <= query_ok ? 13'(mat_rdata) : 13'd0;
          row_level     <= query_ok ? query_level : 6'd0;
          zone_total    <= '0;
          pixel_total   <= '0;
          level_total   <= '0;
          largest_zone  <= '0;
          status        <= query_ok ? ST_OK : ST_RANGE;
        end
        S_CLR_WR: begin
          // drop the previous frame's entries
          clr_idx <= clr_idx + CNT_W'(1);
          if ((clr_idx + CNT_W'(1)) == touched_cnt) touched_cnt <= '0;
        end
        S_RANK: begin
          if (rank_present) begin
            rank_of[lvl_i]                <= RW'(distinct);
            level_of_rank[RW'(distinct)]  <= LW'(lvl_i) + LW'(1);
          end
          distinct <= distinct_n;
          highest  <= highest_n;
          lvl_i    <= lvl_i + RW'(1);
          if (lvl_i == RW'(NUM_LEVELS - 1)) begin
            latched_rows <= latched_ibsi ? highest_n : distinct_n;
          end
        end
        S_SCAN_CHK: begin
          if (zone_start) begin
            zone_lev  <= pix_lev;
            zone_size <= '0;
            sp        <= CNT_W'(1);
          end else begin
            scan_p <= scan_p + PAW'(1);
            if ((32'(scan_x) + 1) == 32'(label_w)) begin
              scan_x <= '0;
              scan_y <= scan_y + YW'(1);
            end else begin
              scan_x <= scan_x + XW'(1);
            end
          end
        end
        S_POP: begin
          if (sp != '0) sp <= sp - CNT_W'(1);
        end
        S_POP_DATA: begin
          {q_y, q_x} <= stk_rdata;
          zone_size  <= zone_size + CNT_W'(1);
          nbr_k      <= '0;
        end
        S_NBR_ADDR: begin
          if (nbr_ok) begin
            nbr_y    <= ny;
            nbr_x    <= nx;
            nbr_addr <= nbr_lin;
          end else begin
            nbr_k <= nbr_k + 3'd1;
          end
        end
        S_NBR_CHK: begin
          if (nbr_match) sp <= sp + CNT_W'(1);
          nbr_k <= nbr_k + 3'd1;
        end
        S_ZONE_WR: begin
          zone_counter <= zone_counter + CNT_W'(1);
          if (zone_size > biggest_zone) biggest_zone <= zone_size;
          if (mat_rdata == '0) touched_cnt <= touched_cnt + CNT_W'(1);
          scan_p <= scan_p + PAW'(1);
          if ((32'(scan_x) + 1) == 32'(label_w)) begin
            scan_x <= '0;
            scan_y <= scan_y + YW'(1);
          end else begin
            scan_x <= scan_x + XW'(1);
          end
        end
        S_DONE: begin
          result_strobe <= 1'b1;
          result_kind   <= KIND_SUMMARY;
          zone_count    <= '0;
          row_level     <= '0;
          zone_total    <= 13'(zone_counter);
          pixel_total   <= 13'(nonzero_counter);
          level_total   <= 6'(latched_rows);
          largest_zone  <= 13'(biggest_zone);
          status        <= (nonzero_counter == '0) ? ST_EMPTY : ST_OK;
        end
        default: sp <= sp;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  `GLSZM_ASSERT_NOW(a_strobe_after_work, result_strobe, $past(busy),
    "result word without preceding work")
  `GLSZM_ASSERT_NOW(a_stack_empty_idle, state == S_IDLE, sp == '0,
    "walk stack not empty while idle")
  `GLSZM_ASSERT_NOW(a_empty_status, result_strobe && (result_kind == KIND_SUMMARY),
    (status == ST_EMPTY) == (pixel_total == '0), "summary status disagrees with pixel total")
  `GLSZM_ASSERT_NEXT(a_query_answer, accept && (mode == MODE_QUERY), ##1 result_strobe,
    "query answer not delivered two cycles after accept")

endmodule
